@@ rtl/core/rc5_pkg.sv @@
// rc5_pkg: types, constants and helper functions for the RC5 block cipher unit.
// No dependencies; used by rc5_if, rc5_cell and the top level of the core.
`timescale 1ns / 1ps
package rc5_pkg;

   localparam logic [31:0] RC5_P = 32'hb7e15163;
   localparam logic [31:0] RC5_Q = 32'h9e3779b9;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_ALIGN,
      ST_RUN,
      ST_DONE
   } rc5_state_type;

   // shift/load controls shared by every cell of a ring
   typedef struct packed {
      logic load;
      logic fwd;
      logic bwd;
   } rc5_cell_ctrl_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} >> s;
      return t[31:0];
   endfunction

   // initial table word k: P + k*Q mod 2^32
   function automatic logic [31:0] fill_word(input int k);
      logic [63:0] t;
      t = 64'(RC5_P) + 64'(RC5_Q) * 64'(k);
      return t[31:0];
   endfunction

endpackage

@@ rtl/core/rc5_if.sv @@
// rc5_if: valid/ready channel interfaces for requests, responses and CSR writes.
// Depends on rc5_pkg for the CSR index width.
`timescale 1ns / 1ps
interface rc5_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] in_word_a;
   logic [31:0] in_word_b;
   modport source (output valid, opcode, in_word_a, in_word_b, input ready);
   modport sink   (input valid, opcode, in_word_a, in_word_b, output ready);
endinterface

interface rc5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word_a;
   logic [31:0] out_word_b;
   modport source (output valid, out_word_a, out_word_b, input ready);
   modport sink   (input valid, out_word_a, out_word_b, output ready);
endinterface

interface rc5_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rc5_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [63:0]                         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/rc5_block_cipher_unit.sv @@
// rc5_block_cipher_unit: RC5-32 top level, rings of word cells plus the sequencer.
// Depends on rc5_pkg, rc5_if and rc5_cell.
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    opcode, in_word_a, in_word_b
//   rsp_bus  out  valid/ready    out_word_a, out_word_b
//   csr_bus  in   valid/ready    index (0 key_low, 1 key_high), data
//
// One item at a time. From the request transfer to rsp_bus.valid an item goes
// through ring rotation to bring the first round key to the head cell, the
// rounds and the done state; the next request can be taken once rsp_bus.valid rises.
// After reset or a key write, the first item also goes through key expansion
// first, one mixing step per cycle through the head cells.
// Synchronous reset clears control state and the key registers only; the result
// register holds while rsp_bus is stalled, and a new request is taken meanwhile.
`timescale 1ns / 1ps
module rc5_block_cipher_unit #(
   parameter int ROUNDS      = 12,
   parameter int TABLE_WORDS = 26,
   parameter int KEY_BYTES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   rc5_req_if.sink     req_bus,
   rc5_rsp_if.source   rsp_bus,
   rc5_csr_if.sink     csr_bus
);
   import rc5_pkg::*;

   localparam int T         = TABLE_WORDS;
   localparam int KW        = (KEY_BYTES + 3) / 4;
   localparam int PW        = (T > 1) ? $clog2(T) : 1;
   localparam int DEC_LAST  = 2 * ROUNDS + 1;
   localparam int IW        = $clog2(DEC_LAST + 1);
   localparam int EXP_STEPS = 3 * T;
   localparam int EW        = $clog2(EXP_STEPS);
   localparam int DEC_START = (DEC_LAST < T) ? DEC_LAST : T - 1;

   // control state
   rc5_state_type state_ff, state_in;
   logic          tready_ff, tready_in;     // round key table built
   logic [PW-1:0] pos_ff, pos_in;           // table index at the head cell
   logic [IW-1:0] idx_ff, idx_in;           // round key index in use
   logic [EW-1:0] cnt_ff, cnt_in;           // expansion step
   logic          out_valid_ff, out_valid_in;

   // payload
   logic        op_ff, op_in;
   logic [31:0] wa_ff, wa_in;
   logic [31:0] wb_ff, wb_in;
   logic [31:0] xa_ff, xa_in;               // expansion A/B
   logic [31:0] xb_ff, xb_in;
   logic [31:0] oa_ff, oa_in;
   logic [31:0] ob_ff, ob_in;
   logic [63:0] key_lo_ff, key_lo_in;
   logic [63:0] key_hi_ff, key_hi_in;

   // rings
   logic [31:0]       ring_q [T];
   logic [31:0]       kring_q [KW];
   rc5_cell_ctrl_type ring_ctrl, kring_ctrl;
   logic              ring_wr;
   logic [31:0]       new_s, new_l, sum_ab, rk;

   genvar gi;
   generate
      for (gi = 0; gi < T; gi++) begin : g_ring
         logic [31:0] fwd_v, bwd_v;
         if (gi < T - 1) begin : g_mid
            assign fwd_v = ring_q[gi+1];
         end else begin : g_tail
            // tail takes the fresh mixed word during expansion, else wraps
            assign fwd_v = ring_wr ? new_s : ring_q[0];
         end
         if (gi > 0) begin : g_bn
            assign bwd_v = ring_q[gi-1];
         end else begin : g_bh
            assign bwd_v = ring_q[T-1];
         end
         rc5_cell u_cell (
            .clock    (clock),
            .ctrl     (ring_ctrl),
            .load_val (fill_word(gi)),
            .fwd_val  (fwd_v),
            .bwd_val  (bwd_v),
            .word     (ring_q[gi])
         );
      end

      for (gi = 0; gi < KW; gi++) begin : g_kring
         logic [31:0] kfwd_v, kload_v;
         if (gi < KW - 1) begin : g_mid
            assign kfwd_v = kring_q[gi+1];
         end else begin : g_tail
            assign kfwd_v = new_l;
         end
         // key word gi from register bytes 4gi..4gi+3, bytes past KEY_BYTES zero
         for (genvar bj = 0; bj < 4; bj++) begin : g_byte
            localparam int N = 4 * gi + bj;
            if (N < KEY_BYTES) begin : g_on
               if (N < 8) begin : g_lo
                  assign kload_v[8*bj +: 8] = key_lo_ff[8*N +: 8];
               end else begin : g_hi
                  assign kload_v[8*bj +: 8] = key_hi_ff[8*(N-8) +: 8];
               end
            end else begin : g_off
               assign kload_v[8*bj +: 8] = 8'h00;
            end
         end
         rc5_cell u_kcell (
            .clock    (clock),
            .ctrl     (kring_ctrl),
            .load_val (kload_v),
            .fwd_val  (kfwd_v),
            .bwd_val  (kfwd_v),
            .word     (kring_q[gi])
         );
      end
   endgenerate

   // expansion step on the head cells
   assign new_s  = rotl32(ring_q[0] + xa_ff + xb_ff, 5'd3);
   assign sum_ab = new_s + xb_ff;
   assign new_l  = rotl32(kring_q[0] + sum_ab, sum_ab[4:0]);

   // round key, indexes past the table read zero
   assign rk = (int'(idx_ff) < T) ? ring_q[0] : 32'h0;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_word_a = oa_ff;
   assign rsp_bus.out_word_b = ob_ff;

   always_comb begin
      state_in     = state_ff;
      tready_in    = tready_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      op_in        = op_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      oa_in        = oa_ff;
      ob_in        = ob_ff;
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      ring_ctrl    = '0;
      kring_ctrl   = '0;
      ring_wr      = 1'b0;

      if (rsp_bus.valid && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in = req_bus.opcode;
               wa_in = req_bus.in_word_a;
               wb_in = req_bus.in_word_b;
               if (!tready_ff) begin
                  ring_ctrl.load  = 1'b1;
                  kring_ctrl.load = 1'b1;
                  pos_in   = '0;
                  cnt_in   = '0;
                  xa_in    = '0;
                  xb_in    = '0;
                  state_in = ST_EXPAND;
               end else begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_EXPAND: begin
            ring_ctrl.fwd  = 1'b1;
            kring_ctrl.fwd = 1'b1;
            ring_wr = 1'b1;
            xa_in   = new_s;
            xb_in   = new_l;
            pos_in  = (int'(pos_ff) == T - 1) ? '0 : pos_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == EW'(EXP_STEPS - 1)) begin
               tready_in = 1'b1;
               state_in  = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (pos_ff == ((op_ff == OP_DECRYPT) ? PW'(DEC_START) : PW'(0))) begin
               idx_in   = (op_ff == OP_DECRYPT) ? IW'(DEC_LAST) : '0;
               state_in = ST_RUN;
            end else begin
               ring_ctrl.fwd = 1'b1;
               pos_in = (int'(pos_ff) == T - 1) ? '0 : pos_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (op_ff == OP_ENCRYPT) begin
               if (idx_ff == IW'(0)) begin
                  wa_in = wa_ff + rk;
               end else if (idx_ff == IW'(1)) begin
                  wb_in = wb_ff + rk;
               end else if (!idx_ff[0]) begin
                  wa_in = rotl32(wa_ff ^ wb_ff, wb_ff[4:0]) + rk;
               end else begin
                  wb_in = rotl32(wb_ff ^ wa_ff, wa_ff[4:0]) + rk;
               end
               if (int'(idx_ff) < T) begin
                  ring_ctrl.fwd = 1'b1;
                  pos_in = (int'(pos_ff) == T - 1) ? '0 : pos_ff + 1'b1;
               end
               if (idx_ff == IW'(DEC_LAST)) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (idx_ff == IW'(0)) begin
                  wa_in = wa_ff - rk;
               end else if (idx_ff == IW'(1)) begin
                  wb_in = wb_ff - rk;
               end else if (idx_ff[0]) begin
                  wb_in = rotr32(wb_ff - rk, wa_ff[4:0]) ^ wa_ff;
               end else begin
                  wa_in = rotr32(wa_ff - rk, wb_ff[4:0]) ^ wb_ff;
               end
               if (int'(idx_ff) < T) begin
                  ring_ctrl.bwd = 1'b1;
                  pos_in = (pos_ff == '0) ? PW'(T - 1) : pos_ff - 1'b1;
               end
               if (idx_ff == IW'(0)) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               oa_in        = wa_ff;
               ob_in        = wb_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // key writes; the user must issue them only while idle, the block does not enforce it
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_KEY_LOW) begin
            key_lo_in = csr_bus.data;
            tready_in = 1'b0;
         end else if (csr_bus.index == CSR_KEY_HIGH) begin
            key_hi_in = csr_bus.data;
            tready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tready_ff    <= 1'b0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         tready_ff    <= tready_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         key_lo_ff    <= key_lo_in;
         key_hi_ff    <= key_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      xa_ff <= xa_in;
      xb_ff <= xb_in;
      oa_ff <= oa_in;
      ob_ff <= ob_in;
   end
endmodule

@@ rtl/core/rc5_cell.sv @@
// rc5_cell: one 32-bit word of a ring; loads, or takes its forward or backward neighbor.
// Depends on rc5_pkg for the control struct.
`timescale 1ns / 1ps
module rc5_cell (
   input  logic                       clock,
   input  rc5_pkg::rc5_cell_ctrl_type ctrl,
   input  logic [31:0]                load_val,
   input  logic [31:0]                fwd_val,
   input  logic [31:0]                bwd_val,
   output logic [31:0]                word
);
   import rc5_pkg::*;

   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = load_val;
      end else if (ctrl.fwd) begin
         word_in = fwd_val;
      end else if (ctrl.bwd) begin
         word_in = bwd_val;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

@@ rtl/core/rc5_checker.sv @@
// rc5_checker: port-level assertions for rc5_block_cipher_unit, plus its bind.
// Depends on the top level's channel interfaces.
`timescale 1ns / 1ps
module rc5_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);
   // a waiting response stays up until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before transfer");

   // an accepted request makes the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // reset leaves no response pending
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // key writes are always taken
   a_csr_rdy: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");
endmodule

bind rc5_block_cipher_unit rc5_checker u_rc5_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_ready (csr_bus.ready)
);
